FILE: hdl/iist_pkg.sv
// ----------------------------------------------------------------------------
// iist_pkg
// Shared constants, widths and helpers for the inverse interpolation stepper
// target unit.
// ----------------------------------------------------------------------------
package iist_pkg;

   // Table geometry and stepper scale
   localparam int NUM_POINTS     = 10;
   localparam int STEPS_PER_TURN = 200;

   localparam int IDX_W  = $clog2(NUM_POINTS);
   localparam int DATA_W = 16;
   localparam int POS_W  = 16;
   localparam int DLT_W  = 17;

   // Segment search bounds
   localparam logic [IDX_W-1:0] LAST_SEG     = IDX_W'(NUM_POINTS - 3);
   localparam logic [IDX_W-1:0] FALLBACK_SEG = IDX_W'(NUM_POINTS - 2);
   localparam logic [IDX_W-1:0] LAST_ENTRY   = IDX_W'(NUM_POINTS - 1);

   // Positions written on calibration end and on a negative quotient
   localparam int CAL_POS_INT = (NUM_POINTS * STEPS_PER_TURN > 65535) ? 65535 :
                                NUM_POINTS * STEPS_PER_TURN;
   localparam logic [POS_W-1:0] CAL_POS    = POS_W'(CAL_POS_INT);
   localparam logic [POS_W-1:0] NEG_TARGET = POS_W'(STEPS_PER_TURN / 10);
   localparam logic [POS_W-1:0] POS_MAX    = '1;

   // Opcodes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_REQUEST = 1'b1;

   // Datapath widths
   localparam int SCL_W   = DATA_W + 4;                      // 9*t or 10*y
   localparam int KM_W    = $clog2(10 * (NUM_POINTS - 1) + 1);
   localparam int SLOPE_W = DATA_W + 1;                      // d, signed
   localparam int PROD_W  = SLOPE_W + KM_W + 1;
   localparam int TERM_W  = SCL_W + 1;
   localparam int INNER_W = ((PROD_W > TERM_W) ? PROD_W : TERM_W) + 1;
   localparam int S_W     = $clog2(STEPS_PER_TURN + 1);
   localparam int NUM_W   = INNER_W + S_W;
   localparam int DEN_W   = SLOPE_W + 4;
   localparam int QUO_W   = NUM_W - 1;
   localparam int DVS_W   = DEN_W - 1;

   localparam logic signed [NUM_W-1:0] STEPS_S = NUM_W'(STEPS_PER_TURN);

   function automatic logic [SCL_W-1:0] times9(input logic [DATA_W-1:0] v);
      logic [SCL_W-1:0] x;
      x = SCL_W'(v);
      return (x << 3) + x;
   endfunction

   function automatic logic [SCL_W-1:0] times10(input logic [DATA_W-1:0] v);
      logic [SCL_W-1:0] x;
      x = SCL_W'(v);
      return (x << 3) + (x << 1);
   endfunction

endpackage

FILE: hdl/iist_table_mem.sv
// ----------------------------------------------------------------------------
// iist_table_mem
// Calibration table storage: one write port, one registered read port, with
// per-entry valid bits so unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module iist_table_mem
   import iist_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0]     mem [NUM_POINTS];
   logic [NUM_POINTS-1:0] valid_ff;
   logic [DATA_W-1:0]     rd_q_ff;
   logic                  rd_vld_ff;

   // Storage array and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   // Valid bits, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

FILE: hdl/iist_divider.sv
// ----------------------------------------------------------------------------
// iist_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module iist_divider
   import iist_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [QUO_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quotient
);

   localparam int CNT_W = $clog2(QUO_W + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   rem_shift;
   logic             fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_shift = {rem_ff, quo_ff[QUO_W-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = CNT_W'(QUO_W);
         quo_in    = dividend;
         rem_in    = '0;
         dvs_in    = divisor;
      end else if (active_ff) begin
         quo_in = {quo_ff[QUO_W-2:0], fits};
         rem_in = fits ? DVS_W'(rem_shift - {1'b0, dvs_ff}) : DVS_W'(rem_shift);
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hdl/inverse_interp_stepper_target_unit.sv
// ----------------------------------------------------------------------------
// inverse_interp_stepper_target_unit
// Calibration table of stroke times with inverse linear interpolation to a
// stepper target position.
// ----------------------------------------------------------------------------
// A load returns nothing. A request is answered after a table scan through the
// single read port, the fetch and arithmetic steps, the 33-step radix-2 divider
// and the output register. A flat segment or a negative quotient skips the divider.
// One request is taken at a time; loads are taken one per cycle when idle.
// Reset clears the table, the position and control.
module inverse_interp_stepper_target_unit
   import iist_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [3:0]              req_entry_index,
   input  logic [15:0]             req_entry_ms,
   input  logic [15:0]             req_inspiration_ms,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_target_steps,
   output logic signed [16:0]      rsp_step_delta,
   output logic                    rsp_div_error
);

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SCAN  = 4'd1;
   localparam logic [3:0] ST_RD0   = 4'd2;
   localparam logic [3:0] ST_RD1   = 4'd3;
   localparam logic [3:0] ST_RD2   = 4'd4;
   localparam logic [3:0] ST_MUL   = 4'd5;
   localparam logic [3:0] ST_SUM   = 4'd6;
   localparam logic [3:0] ST_SCALE = 4'd7;
   localparam logic [3:0] ST_SIGN  = 4'd8;
   localparam logic [3:0] ST_DIV   = 4'd9;
   localparam logic [3:0] ST_DONE  = 4'd10;

   logic [3:0]                state_ff, state_in;
   logic [IDX_W-1:0]          issue_ff, issue_in;
   logic [IDX_W-1:0]          chk_ff, chk_in;
   logic [IDX_W-1:0]          k_ff, k_in;
   logic                      rvld_ff, rvld_in;
   logic [SCL_W-1:0]          t9_ff, t9_in;
   logic [DATA_W-1:0]         y0_ff, y0_in;
   logic [DATA_W-1:0]         y1_ff, y1_in;
   logic signed [SLOPE_W-1:0] d_ff, d_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [TERM_W-1:0]  term_ff, term_in;
   logic signed [INNER_W-1:0] inner_ff, inner_in;
   logic signed [NUM_W-1:0]   num_ff, num_in;
   logic signed [DEN_W-1:0]   den_ff, den_in;
   logic [POS_W-1:0]          res_ff, res_in;
   logic                      err_ff, err_in;
   logic [POS_W-1:0]          position_ff, position_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]          rsp_target_ff, rsp_target_in;
   logic [DLT_W-1:0]          rsp_delta_ff, rsp_delta_in;
   logic                      rsp_err_ff, rsp_err_in;

   logic                      req_fire;
   logic                      mem_wr_en;
   logic [IDX_W-1:0]          mem_rd_addr;
   logic [DATA_W-1:0]         mem_rd_data;
   logic                      div_start;
   logic                      div_done;
   logic [QUO_W-1:0]          div_quotient;
   logic [QUO_W-1:0]          num_abs;
   logic [DVS_W-1:0]          den_abs;
   logic                      neg_quot;
   logic [KM_W-1:0]           kp1;
   logic [KM_W-1:0]           km10;
   logic                      load_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign mem_wr_en = req_fire && (req_opcode == OP_LOAD) &&
                      (req_entry_index < 4'(NUM_POINTS));
   assign load_last = mem_wr_en && (req_entry_index[IDX_W-1:0] == LAST_ENTRY);

   // Table memory
   iist_table_mem u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (req_entry_index[IDX_W-1:0]),
      .wr_data (req_entry_ms),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sign handling and magnitudes for the divider
   assign neg_quot  = (num_ff != '0) && (num_ff[NUM_W-1] != den_ff[DEN_W-1]);
   assign num_abs   = num_ff[NUM_W-1] ? QUO_W'(-num_ff) : QUO_W'(num_ff);
   assign den_abs   = den_ff[DEN_W-1] ? DVS_W'(-den_ff) : DVS_W'(den_ff);
   assign div_start = (state_ff == ST_SIGN) && !neg_quot;

   iist_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_abs),
      .divisor  (den_abs),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // 10*(k+1) for the chosen segment
   assign kp1  = KM_W'(k_ff) + KM_W'(1);
   assign km10 = (kp1 << 3) + (kp1 << 1);

   // Sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      chk_in        = chk_ff;
      k_in          = k_ff;
      rvld_in       = 1'b0;
      t9_in         = t9_ff;
      y0_in         = y0_ff;
      y1_in         = y1_ff;
      d_in          = d_ff;
      prod_in       = prod_ff;
      term_in       = term_ff;
      inner_in      = inner_ff;
      num_in        = num_ff;
      den_in        = den_ff;
      res_in        = res_ff;
      err_in        = err_ff;
      position_in   = position_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_target_in = rsp_target_ff;
      rsp_delta_in  = rsp_delta_ff;
      rsp_err_in    = rsp_err_ff;
      mem_rd_addr   = k_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_opcode == OP_REQUEST) begin
                  t9_in    = times9(req_inspiration_ms);
                  issue_in = '0;
                  chk_in   = '0;
                  state_in = ST_SCAN;
               end else if (load_last) begin
                  position_in = CAL_POS;
               end
            end
         end
         // Read entries 1..N-2 back to back, compare in the next cycle
         ST_SCAN: begin
            mem_rd_addr = issue_ff + IDX_W'(1);
            if (issue_ff <= LAST_SEG) begin
               issue_in = issue_ff + IDX_W'(1);
               rvld_in  = 1'b1;
            end
            if (rvld_ff) begin
               if (t9_ff > times10(mem_rd_data)) begin
                  k_in     = chk_ff;
                  state_in = ST_RD0;
               end else if (chk_ff == LAST_SEG) begin
                  k_in     = FALLBACK_SEG;
                  state_in = ST_RD0;
               end else begin
                  chk_in = chk_ff + IDX_W'(1);
               end
            end
         end
         ST_RD0: begin
            mem_rd_addr = k_ff;
            state_in    = ST_RD1;
         end
         ST_RD1: begin
            mem_rd_addr = k_ff + IDX_W'(1);
            y0_in       = mem_rd_data;
            state_in    = ST_RD2;
         end
         ST_RD2: begin
            y1_in    = mem_rd_data;
            state_in = ST_MUL;
         end
         // d, 10*(k+1)*d and 9t - 10*y_k
         ST_MUL: begin
            d_in     = signed'({1'b0, y1_ff}) - signed'({1'b0, y0_ff});
            prod_in  = PROD_W'(signed'({1'b0, km10})) * PROD_W'(d_in);
            term_in  = signed'({1'b0, t9_ff}) - signed'({1'b0, times10(y0_ff)});
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (d_ff == '0) begin
               err_in   = 1'b1;
               res_in   = position_ff;
               state_in = ST_DONE;
            end else begin
               err_in   = 1'b0;
               inner_in = INNER_W'(prod_ff) + INNER_W'(term_ff);
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            num_in   = NUM_W'(inner_ff) * STEPS_S;
            den_in   = (DEN_W'(d_ff) <<< 3) + (DEN_W'(d_ff) <<< 1);
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            if (neg_quot) begin
               res_in   = NEG_TARGET;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in   = (div_quotient > QUO_W'(POS_MAX)) ? POS_MAX :
                          div_quotient[POS_W-1:0];
               state_in = ST_DONE;
            end
         end
         // Hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_target_in = res_ff;
               rsp_err_in    = err_ff;
               rsp_delta_in  = err_ff ? '0 :
                               {1'b0, position_ff} - {1'b0, res_ff};
               if (!err_ff) begin
                  position_in = res_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         chk_ff       <= '0;
         rvld_ff      <= 1'b0;
         position_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         chk_ff       <= chk_in;
         rvld_ff      <= rvld_in;
         position_ff  <= position_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      t9_ff         <= t9_in;
      y0_ff         <= y0_in;
      y1_ff         <= y1_in;
      d_ff          <= d_in;
      prod_ff       <= prod_in;
      term_ff       <= term_in;
      inner_ff      <= inner_in;
      num_ff        <= num_in;
      den_ff        <= den_in;
      res_ff        <= res_in;
      err_ff        <= err_in;
      rsp_target_ff <= rsp_target_in;
      rsp_delta_ff  <= rsp_delta_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_steps = rsp_target_ff;
   assign rsp_step_delta   = signed'(rsp_delta_ff);
   assign rsp_div_error    = rsp_err_ff;

`ifndef SYNTHESIS
   // A flat segment reports no motion
   a_err_no_motion: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_error) |-> (rsp_step_delta == '0))
      else $error("flat-segment result with nonzero motion");

   // Position moves only on a finished request or a calibration end
   a_position_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_DONE && !load_last) |=> $stable(position_ff))
      else $error("position changed outside of a result or calibration end");

   // Divider completes only while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider finished outside of the divide state");

   // Divider starts only from the sign state with the request in flight
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == ST_DIV && !req_ready))
      else $error("divider started without entering the divide state");
`endif

endmodule
